// ===== hdl/lru_recency_stack_core_macros.svh =====
// assertion macros for the lru recency stack core
`ifndef LRU_RECENCY_STACK_CORE_MACROS_SVH
`define LRU_RECENCY_STACK_CORE_MACROS_SVH

// property that must hold at every clock edge outside reset
`define LRS_ASSERT_NOW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define LRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lrs_pkg.sv =====
// types, constants and cell commands for the lru recency stack
`default_nettype none

package lrs_pkg;

  // geometry
  localparam int unsigned DEPTH = 16;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned ACT_W = 3;
  localparam int unsigned STS_W = 2;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // requested action, codes above touch mean no operation
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_EVICT  = 3'd3,
    ACT_TOUCH  = 3'd4
  } action_e;

  // result status
  typedef enum logic [STS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // what each cell does with its key this cycle
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_SHIFT_DOWN,
    CMD_SHIFT_UP,
    CMD_UP_FROM_MATCH,
    CMD_DOWN_TO_MATCH
  } cell_cmd_e;

  // control broadcast to every cell
  typedef struct packed {
    cell_cmd_e        cmd;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/lrs_in_if.sv =====
// request channel of the lru recency stack
`default_nettype none

interface lrs_in_if;

  logic                       valid;
  logic                       ready;
  logic [lrs_pkg::ACT_W-1:0]  action;
  logic [lrs_pkg::KEY_W-1:0]  key;

  modport source (output valid, output action, output key, input ready);
  modport sink (input valid, input action, input key, output ready);

endinterface

`default_nettype wire

// ===== hdl/lrs_out_if.sv =====
// result channel of the lru recency stack
`default_nettype none

interface lrs_out_if #(
  parameter int unsigned CntW = lrs_pkg::CNT_W
);

  logic                       valid;
  logic                       ready;
  logic [lrs_pkg::KEY_W-1:0]  out_key;
  logic                       hit;
  logic [lrs_pkg::STS_W-1:0]  status;
  logic [CntW-1:0]            entry_count;

  modport source (output valid, output out_key, output hit, output status,
                  output entry_count, input ready);
  modport sink (input valid, input out_key, input hit, input status,
                input entry_count, output ready);

endinterface

`default_nettype wire

// ===== hdl/lrs_cell.sv =====
// one slot of the recency stack: key register, compare and neighbor shift
`default_nettype none

module lrs_cell (
  input  wire                       clk_i,
  input  wire lrs_pkg::cell_ctl_t   ctl_i,
  input  wire [lrs_pkg::KEY_W-1:0]  above_key_i,
  input  wire [lrs_pkg::KEY_W-1:0]  below_key_i,
  input  wire                       occ_i,
  input  wire                       match_above_i,
  output logic                      match_o,
  output logic [lrs_pkg::KEY_W-1:0] key_o
);

  logic [lrs_pkg::KEY_W-1:0] key_q, key_d;
  logic                      own_match;

  // match ripple: set from the topmost matching occupied slot downward
  assign own_match = occ_i && (key_q == ctl_i.key);
  assign match_o   = match_above_i | own_match;
  assign key_o     = key_q;

  // next key from own value or a neighbor
  always_comb begin
    key_d = key_q;
    case (ctl_i.cmd)
      lrs_pkg::CMD_HOLD:          key_d = key_q;
      lrs_pkg::CMD_SHIFT_DOWN:    key_d = above_key_i;
      lrs_pkg::CMD_SHIFT_UP:      key_d = below_key_i;
      lrs_pkg::CMD_UP_FROM_MATCH: key_d = match_o ? below_key_i : key_q;
      lrs_pkg::CMD_DOWN_TO_MATCH: key_d = match_above_i ? key_q : above_key_i;
      default:                    key_d = key_q;
    endcase
  end

  // key storage, contents meaningful only while occupied
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

`default_nettype wire

// ===== hdl/lru_recency_stack_core.sv =====
// top level of the lru recency stack: cell row, fill count and result register
//
// channel  | dir | payload                              | transaction
// in_i     | in  | action, key                          | valid & ready
// out_o    | out | out_key, hit, status, entry_count    | valid & ready
//
// one transaction per cycle while in_i.ready is high; the whole update happens at the accepting edge
// the critical path is the key compare rippling its match flag down the row
// of Depth cells, followed by the shift select in each cell
// reset empties the stack (fill count zero); cell keys are not cleared
// in_i.ready drops only while a result waits in the output register unread
`default_nettype none

`include "lru_recency_stack_core_macros.svh"

module lru_recency_stack_core #(
  parameter int unsigned Depth = lrs_pkg::DEPTH
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  lrs_in_if.sink     in_i,
  lrs_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned IdxW = $clog2(Depth);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic [lrs_pkg::KEY_W-1:0]  okey_q, okey_d;
  logic                       hit_q, hit_d;
  lrs_pkg::status_e           status_q, status_d;

  lrs_pkg::action_e           act;
  lrs_pkg::cell_ctl_t         ctl;
  logic                       accept;
  logic                       full, empty, hit_any;
  logic [Depth:0]             match_chain;
  logic [lrs_pkg::KEY_W-1:0]  cell_key [Depth];
  logic [IdxW-1:0]            bottom_idx;

  // handshake
  assign accept     = in_i.valid & in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign act        = lrs_pkg::action_e'(in_i.action);

  assign full        = (cnt_q == CntFull);
  assign empty       = (cnt_q == '0);
  assign hit_any     = match_chain[Depth];
  assign bottom_idx  = IdxW'(cnt_q - CntOne);
  assign match_chain[0] = 1'b0;

  // row of cells
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    localparam logic [CntW-1:0] Pos = CntW'(i);
    logic [lrs_pkg::KEY_W-1:0] above_key, below_key;

    if (i == 0) begin : g_top
      assign above_key = in_i.key;
    end else begin : g_mid
      assign above_key = cell_key[i-1];
    end
    if (i == Depth - 1) begin : g_bot
      assign below_key = cell_key[i];
    end else begin : g_up
      assign below_key = cell_key[i+1];
    end

    lrs_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .above_key_i   (above_key),
      .below_key_i   (below_key),
      .occ_i         (cnt_q > Pos),
      .match_above_i (match_chain[i]),
      .match_o       (match_chain[i+1]),
      .key_o         (cell_key[i])
    );
  end

  // action decode: cell command, count and result
  always_comb begin
    ctl.key  = in_i.key;
    ctl.cmd  = lrs_pkg::CMD_HOLD;
    cnt_d    = cnt_q;
    okey_d   = '0;
    hit_d    = 1'b0;
    status_d = lrs_pkg::ST_OK;
    if (accept) begin
      case (act)
        lrs_pkg::ACT_PUSH: begin
          if (full) begin
            status_d = lrs_pkg::ST_FULL;
          end else begin
            ctl.cmd = lrs_pkg::CMD_SHIFT_DOWN;
            cnt_d   = cnt_q + CntOne;
          end
        end
        lrs_pkg::ACT_POP: begin
          if (empty) begin
            status_d = lrs_pkg::ST_EMPTY;
          end else begin
            okey_d  = cell_key[0];
            ctl.cmd = lrs_pkg::CMD_SHIFT_UP;
            cnt_d   = cnt_q - CntOne;
          end
        end
        lrs_pkg::ACT_REMOVE: begin
          if (empty) begin
            status_d = lrs_pkg::ST_EMPTY;
          end else if (hit_any) begin
            okey_d  = in_i.key;
            hit_d   = 1'b1;
            ctl.cmd = lrs_pkg::CMD_UP_FROM_MATCH;
            cnt_d   = cnt_q - CntOne;
          end else begin
            status_d = lrs_pkg::ST_NOTFOUND;
          end
        end
        lrs_pkg::ACT_EVICT: begin
          if (empty) begin
            status_d = lrs_pkg::ST_EMPTY;
          end else begin
            okey_d = cell_key[bottom_idx];
            cnt_d  = cnt_q - CntOne;
          end
        end
        lrs_pkg::ACT_TOUCH: begin
          if (hit_any) begin
            hit_d   = 1'b1;
            ctl.cmd = lrs_pkg::CMD_DOWN_TO_MATCH;
          end else if (full) begin
            status_d = lrs_pkg::ST_FULL;
          end else begin
            ctl.cmd = lrs_pkg::CMD_SHIFT_DOWN;
            cnt_d   = cnt_q + CntOne;
          end
        end
        default: begin
          ctl.cmd = lrs_pkg::CMD_HOLD;
        end
      endcase
    end
  end

  assign out_valid_d = accept || (out_valid_q && !out_o.ready);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register, loaded per accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      okey_q   <= okey_d;
      hit_q    <= hit_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_key     = okey_q;
  assign out_o.hit         = hit_q;
  assign out_o.status      = status_q;
  assign out_o.entry_count = cnt_q;

  // checks
  `LRS_ASSERT_NOW(a_cnt_bound, cnt_q <= CntFull, "fill count above depth")
  `LRS_ASSERT_NEXT(a_cnt_idle, !accept, $stable(cnt_q), "fill count moved without transaction")
  `LRS_ASSERT_NOW(a_full_status, !(out_valid_q && status_q == lrs_pkg::ST_FULL) || full, "full status with room left")
  `LRS_ASSERT_NEXT(a_hit_result, accept && hit_any && (act == lrs_pkg::ACT_REMOVE || act == lrs_pkg::ACT_TOUCH), hit_q && status_q == lrs_pkg::ST_OK, "match not reported as hit")

endmodule

`default_nettype wire

// ===== bench/tb_lru_recency_stack_core.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the lru recency stack core
module tb_lru_recency_stack_core;

  localparam int unsigned KeyW        = lrs_pkg::KEY_W;
  localparam int unsigned ActW        = lrs_pkg::ACT_W;
  localparam int unsigned CntW        = lrs_pkg::CNT_W;
  localparam int unsigned Depth       = lrs_pkg::DEPTH;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandItems   = 620;
  localparam int unsigned PrintLimit  = 40;

  // action codes the block treats as no operation
  localparam logic [ActW-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ActW-1:0] ACT_SPARE_HI = 3'd7;

  // direction the random stream pushes the fill level
  typedef enum int {
    TREND_GROW,
    TREND_SHRINK,
    TREND_MIXED
  } fill_trend_e;

  typedef struct {
    logic [KeyW-1:0]   out_key;
    logic              hit;
    lrs_pkg::status_e  status;
    logic [CntW-1:0]   count;
  } access_result_t;

  typedef struct {
    logic [ActW-1:0] action;
    logic [KeyW-1:0] key;
    bit              fixed;
    access_result_t  want;
  } access_row_t;

  logic clk_i;
  logic rst_ni;

  lrs_in_if  in_if ();
  lrs_out_if out_if ();

  lru_recency_stack_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // shadow copy of the recency stack, slot 0 is the most recent
  logic [KeyW-1:0] shadow_keys [Depth];
  int              shadow_fill = 0;

  access_result_t  pending_results [$];
  access_row_t     directed_rows [$];
  logic [KeyW-1:0] key_pool [8];

  // typed expectation travels with the transaction it belongs to
  bit             row_fixed;
  access_result_t row_want;
  access_result_t blank_result;

  int          tx_idle_pct = 15;
  int          rx_idle_pct = 85;
  logic        hold_go = 1'b0;
  logic        rx_hold = 1'b0;
  int unsigned n_sent = 0;
  int unsigned n_results = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // index of the topmost entry equal to k, -1 when absent
  function automatic int find_topmost(logic [KeyW-1:0] k);
    int pos;
    pos = -1;
    for (int i = shadow_fill - 1; i >= 0; i--) begin
      if (shadow_keys[i] == k) pos = i;
    end
    return pos;
  endfunction

  // close the gap left by slot pos
  function automatic void drop_slot(int pos);
    for (int i = pos; i < shadow_fill - 1; i++) shadow_keys[i] = shadow_keys[i + 1];
    shadow_fill--;
  endfunction

  function automatic void put_top(logic [KeyW-1:0] k);
    for (int i = shadow_fill; i > 0; i--) shadow_keys[i] = shadow_keys[i - 1];
    shadow_keys[0] = k;
    shadow_fill++;
  endfunction

  // apply one access to the shadow stack and return the expected result
  function automatic access_result_t apply_access(logic [ActW-1:0] act, logic [KeyW-1:0] k);
    access_result_t r;
    int             pos;
    r.out_key = '0;
    r.hit     = 1'b0;
    r.status  = lrs_pkg::ST_OK;
    pos = find_topmost(k);
    case (act)
      lrs_pkg::ACT_PUSH: begin
        if (shadow_fill >= Depth) r.status = lrs_pkg::ST_FULL;
        else put_top(k);
      end
      lrs_pkg::ACT_POP: begin
        if (shadow_fill == 0) begin
          r.status = lrs_pkg::ST_EMPTY;
        end else begin
          r.out_key = shadow_keys[0];
          drop_slot(0);
        end
      end
      lrs_pkg::ACT_REMOVE: begin
        if (shadow_fill == 0) begin
          r.status = lrs_pkg::ST_EMPTY;
        end else if (pos < 0) begin
          r.status = lrs_pkg::ST_NOTFOUND;
        end else begin
          r.out_key = shadow_keys[pos];
          r.hit     = 1'b1;
          drop_slot(pos);
        end
      end
      lrs_pkg::ACT_EVICT: begin
        if (shadow_fill == 0) begin
          r.status = lrs_pkg::ST_EMPTY;
        end else begin
          r.out_key = shadow_keys[shadow_fill - 1];
          shadow_fill--;
        end
      end
      lrs_pkg::ACT_TOUCH: begin
        if (pos >= 0) begin
          r.hit = 1'b1;
          drop_slot(pos);
          put_top(k);
        end else if (shadow_fill >= Depth) begin
          r.status = lrs_pkg::ST_FULL;
        end else begin
          put_top(k);
        end
      end
      default: ;
    endcase
    r.count = CntW'(shadow_fill);
    return r;
  endfunction

  function automatic void add_row(logic [ActW-1:0] act, logic [KeyW-1:0] k, bit fixed,
                                  logic [KeyW-1:0] okey, logic hit, lrs_pkg::status_e st,
                                  int cnt);
    access_row_t row;
    row.action       = act;
    row.key          = k;
    row.fixed        = fixed;
    row.want.out_key = okey;
    row.want.hit     = hit;
    row.want.status  = st;
    row.want.count   = CntW'(cnt);
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(string field, logic [KeyW-1:0] want, logic [KeyW-1:0] got);
    if (mismatch_count < PrintLimit)
      $display("result %0d: %s expected %0h got %0h", n_results, field, want, got);
    mismatch_count++;
  endtask

  // offer one transaction, with a random gap first, and wait for it to be taken
  task automatic send_access(logic [ActW-1:0] act, logic [KeyW-1:0] k, bit fixed,
                             access_result_t want);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.key    <= k;
    row_fixed    <= fixed;
    row_want     <= want;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    n_sent++;
  endtask

  // stop offering and wait until every expected result has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (n_results < n_sent);
  endtask

  function automatic logic [ActW-1:0] pick_action(fill_trend_e trend);
    int roll;
    roll = $urandom_range(99);
    if (roll >= 96) return ActW'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
    case (trend)
      TREND_GROW: begin
        if (roll < 45) return lrs_pkg::ACT_PUSH;
        if (roll < 80) return lrs_pkg::ACT_TOUCH;
        if (roll < 87) return lrs_pkg::ACT_REMOVE;
        if (roll < 92) return lrs_pkg::ACT_POP;
        return lrs_pkg::ACT_EVICT;
      end
      TREND_SHRINK: begin
        if (roll < 10) return lrs_pkg::ACT_PUSH;
        if (roll < 30) return lrs_pkg::ACT_TOUCH;
        if (roll < 55) return lrs_pkg::ACT_REMOVE;
        if (roll < 75) return lrs_pkg::ACT_POP;
        return lrs_pkg::ACT_EVICT;
      end
      default: begin
        if (roll < 25) return lrs_pkg::ACT_PUSH;
        if (roll < 50) return lrs_pkg::ACT_TOUCH;
        if (roll < 70) return lrs_pkg::ACT_REMOVE;
        if (roll < 80) return lrs_pkg::ACT_POP;
        return lrs_pkg::ACT_EVICT;
      end
    endcase
  endfunction

  // keys mostly from a small pool so that hits and duplicates are common
  function automatic logic [KeyW-1:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return key_pool[$urandom_range(7)];
    if (roll < 90) return $urandom;
    return roll[0] ? '1 : '0;
  endfunction

  // receiver ready with random stalls and one long hold-off
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin : rx_holdoff
    wait (hold_go);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // predict on every accepted request, check every accepted result
  always @(posedge clk_i) begin : scoreboard
    access_result_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        want = apply_access(in_if.action, in_if.key);
        if (row_fixed) want = row_want;
        pending_results.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, out_key", '0, out_if.out_key);
        end else begin
          want = pending_results.pop_front();
          if (out_if.out_key !== want.out_key)
            report_mismatch("out_key", want.out_key, out_if.out_key);
          if (out_if.hit !== want.hit)
            report_mismatch("hit", KeyW'(want.hit), KeyW'(out_if.hit));
          if (out_if.status !== want.status)
            report_mismatch("status", KeyW'(want.status), KeyW'(out_if.status));
          if (out_if.entry_count !== want.count)
            report_mismatch("entry_count", KeyW'(want.count), KeyW'(out_if.entry_count));
          n_results++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("lru_recency_stack_core: mismatch");
      $finish;
    end
  end

  // stimulus
  initial begin
    fill_trend_e     trend;
    logic [ActW-1:0] act;
    blank_result.out_key = '0;
    blank_result.hit     = 1'b0;
    blank_result.status  = lrs_pkg::ST_OK;
    blank_result.count   = '0;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.action <= lrs_pkg::ACT_PUSH;
    in_if.key    <= '0;
    row_fixed    <= 1'b0;
    row_want     <= blank_result;

    // empty stack corner cases
    add_row(lrs_pkg::ACT_POP, '0, 1'b1, '0, 1'b0, lrs_pkg::ST_EMPTY, 0);
    add_row(lrs_pkg::ACT_REMOVE, 32'h1234_5678, 1'b1, '0, 1'b0, lrs_pkg::ST_EMPTY, 0);
    add_row(lrs_pkg::ACT_EVICT, '1, 1'b1, '0, 1'b0, lrs_pkg::ST_EMPTY, 0);
    // touch of an empty stack pushes, pop of the only entry empties it
    add_row(lrs_pkg::ACT_TOUCH, '1, 1'b1, '0, 1'b0, lrs_pkg::ST_OK, 1);
    add_row(lrs_pkg::ACT_POP, '0, 1'b1, '1, 1'b0, lrs_pkg::ST_OK, 0);
    add_row(ACT_SPARE_LO, '1, 1'b1, '0, 1'b0, lrs_pkg::ST_OK, 0);
    // duplicates, remove miss, touch hit, topmost remove, evict bottom
    add_row(lrs_pkg::ACT_PUSH, '0, 1'b1, '0, 1'b0, lrs_pkg::ST_OK, 1);
    add_row(lrs_pkg::ACT_PUSH, '1, 1'b1, '0, 1'b0, lrs_pkg::ST_OK, 2);
    add_row(lrs_pkg::ACT_PUSH, '0, 1'b1, '0, 1'b0, lrs_pkg::ST_OK, 3);
    add_row(lrs_pkg::ACT_REMOVE, 32'hDEAD_BEEF, 1'b1, '0, 1'b0, lrs_pkg::ST_NOTFOUND, 3);
    add_row(lrs_pkg::ACT_TOUCH, '1, 1'b0, '0, 1'b0, lrs_pkg::ST_OK, 0);
    add_row(lrs_pkg::ACT_REMOVE, '0, 1'b0, '0, 1'b0, lrs_pkg::ST_OK, 0);
    add_row(ACT_SPARE_HI, '0, 1'b1, '0, 1'b0, lrs_pkg::ST_OK, 2);
    add_row(lrs_pkg::ACT_EVICT, '0, 1'b0, '0, 1'b0, lrs_pkg::ST_OK, 0);
    // walking ones fill the stack, the last push is refused
    for (int i = 0; i < Depth; i++)
      add_row(lrs_pkg::ACT_PUSH, KeyW'(1) << i, 1'b0, '0, 1'b0, lrs_pkg::ST_OK, 0);
    add_row(lrs_pkg::ACT_TOUCH, 32'hA5A5_5A5A, 1'b1, '0, 1'b0, lrs_pkg::ST_FULL, Depth);
    add_row(lrs_pkg::ACT_TOUCH, '1, 1'b0, '0, 1'b0, lrs_pkg::ST_OK, 0);
    add_row(lrs_pkg::ACT_REMOVE, 32'h0000_0080, 1'b0, '0, 1'b0, lrs_pkg::ST_OK, 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_access(directed_rows[i].action, directed_rows[i].key, directed_rows[i].fixed,
                  directed_rows[i].want);

    // random traffic in three idling phases
    trend = TREND_GROW;
    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          tx_idle_pct = 15;
          rx_idle_pct = 85;
        end
        1: begin
          tx_idle_pct = 85;
          rx_idle_pct = 15;
          hold_go <= 1'b1;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int j = 0; j < 8; j++) key_pool[j] = (j < 2) ? KeyW'($urandom_range(3)) : $urandom;
      for (int n = 0; n < RandItems / 3; n++) begin
        if (n % 32 == 0) trend = fill_trend_e'($urandom_range(2));
        act = pick_action(trend);
        send_access(act, pick_key(), 1'b0, blank_result);
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered, count", KeyW'(pending_results.size()), '0);
    if (mismatch_count == 0) begin
      $display("lru_recency_stack_core: match");
    end else begin
      $display("lru_recency_stack_core: mismatch");
    end
    $finish;
  end

endmodule
